FILE: design/qbf_pkg.sv
// Shared types and constants for the quadratic Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none
package qbf_pkg;

	localparam int COORD_W = 32;
	localparam int SHIFT_W = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int AUTO_PRESHIFT = 10;
	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 16'd257;
	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd128;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLATNESS_THRESHOLD = 8'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} qbf_curve_t;

	typedef struct packed {
		qbf_curve_t curve;
		logic [SHIFT_W-1:0] shift;
	} qbf_seg_t;

	typedef struct packed {
		qbf_seg_t seg;
		logic overflow;
	} qbf_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qbf_qstat_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAG,
		F_ERR,
		F_SHIFT,
		F_PUSH
	} qbf_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SPLIT,
		B_INIT0,
		B_INIT1,
		B_STEP,
		B_OVF
	} qbf_back_state_t;

endpackage
`default_nettype wire

FILE: design/qbf_front.sv
// Front end: request intake, depth estimate, vector count and overflow check.
`timescale 1ns / 1ps
`default_nettype none
module qbf_front
	import qbf_pkg::*;
#(
	parameter int MAX_SHIFT = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_W-1:0]    start_x,
	input  wire logic signed [COORD_W-1:0]    start_y,
	input  wire logic signed [COORD_W-1:0]    ctrl_x,
	input  wire logic signed [COORD_W-1:0]    ctrl_y,
	input  wire logic signed [COORD_W-1:0]    end_x,
	input  wire logic signed [COORD_W-1:0]    end_y,
	input  wire logic signed [SHIFT_W-1:0]    subdivision_shift,
	input  wire logic                         restart,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	input  wire qbf_qstat_t                   qstat,
	output logic                              push,
	output qbf_item_t                         push_item
);

	localparam int MAG_W = COORD_W + 3;
	localparam int ERR_W = MAG_W + 2;

	qbf_front_state_t state_q, state_d;
	qbf_curve_t curve_q;
	logic auto_q, restart_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [MAG_W-1:0] ex_q, ey_q;
	logic [ERR_W-1:0] err_q;
	logic [CFG_DATA_W-1:0] capacity_q, threshold_q, count_q;
	logic in_accept;
	qbf_curve_t curve_in;
	logic signed [MAG_W-1:0] sx, sy;
	logic [ERR_W-1:0] err_d;
	logic [SHIFT_W-1:0] depth_d, fixed_d;
	logic [CFG_DATA_W:0] sum;

	assign in_stall = (state_q != F_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		curve_in = '{start_x, start_y, ctrl_x, ctrl_y, end_x, end_y};
		if (subdivision_shift[SHIFT_W-1]) begin
			curve_in.ax = start_x >>> AUTO_PRESHIFT;
			curve_in.ay = start_y >>> AUTO_PRESHIFT;
			curve_in.bx = ctrl_x >>> AUTO_PRESHIFT;
			curve_in.by = ctrl_y >>> AUTO_PRESHIFT;
			curve_in.cx = end_x >>> AUTO_PRESHIFT;
			curve_in.cy = end_y >>> AUTO_PRESHIFT;
		end
		fixed_d = {1'b0, subdivision_shift[SHIFT_W-2:0]};
		if (fixed_d > SHIFT_W'(MAX_SHIFT))
			fixed_d = SHIFT_W'(MAX_SHIFT);
	end

	always_comb begin
		sx = MAG_W'(curve_q.ax) - (MAG_W'(curve_q.bx) <<< 1) + MAG_W'(curve_q.cx);
		sy = MAG_W'(curve_q.ay) - (MAG_W'(curve_q.by) <<< 1) + MAG_W'(curve_q.cy);
		if (ex_q > ey_q)
			err_d = ERR_W'(ex_q) + ERR_W'(ex_q) + ERR_W'(ey_q);
		else
			err_d = ERR_W'(ex_q) + ERR_W'(ey_q) + ERR_W'(ey_q);
		depth_d = SHIFT_W'(1);
		for (int j = 0; j < MAX_SHIFT - 1; j++) begin
			if ((err_q >> (2 * j)) > ERR_W'(threshold_q))
				depth_d = depth_d + SHIFT_W'(1);
		end
		sum = (restart_q ? '0 : {1'b0, count_q}) + ((CFG_DATA_W + 1)'(1) << shift_q);
	end

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid)
					state_d = subdivision_shift[SHIFT_W-1] ? F_MAG : F_PUSH;
			end
			F_MAG: state_d = F_ERR;
			F_ERR: state_d = F_SHIFT;
			F_SHIFT: state_d = F_PUSH;
			F_PUSH: begin
				if (!qstat.full) begin
					push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		push_item.seg.curve = curve_q;
		push_item.seg.shift = shift_q;
		push_item.overflow = auto_q && (sum > (CFG_DATA_W + 1)'(capacity_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			capacity_q <= CAPACITY_RESET;
			threshold_q <= THRESHOLD_RESET;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_VECTOR_CAPACITY)
					capacity_q <= cfg_data;
				else if (cfg_index == CFG_FLATNESS_THRESHOLD)
					threshold_q <= cfg_data;
			end
			if (push) begin
				if (auto_q)
					count_q <= sum[CFG_DATA_W] ? '1 : sum[CFG_DATA_W-1:0];
				else if (restart_q)
					count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			curve_q <= curve_in;
			auto_q <= subdivision_shift[SHIFT_W-1];
			restart_q <= restart;
			shift_q <= fixed_d;
		end
		if (state_q == F_MAG) begin
			ex_q <= sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
			ey_q <= sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
		end
		if (state_q == F_ERR)
			err_q <= err_d;
		if (state_q == F_SHIFT)
			shift_q <= depth_d;
	end

endmodule
`default_nettype wire

FILE: design/qbf_queue.sv
// Two-entry queue between the front end and the point generator.
`timescale 1ns / 1ps
`default_nettype none
module qbf_queue
	import qbf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire qbf_item_t push_item,
	input  wire logic      pop,
	output qbf_item_t      pop_item,
	output qbf_qstat_t     qstat
);

	qbf_item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign qstat.full = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: design/qbf_back.sv
// Point generator: midpoint split stack and forward-difference stepping.
`timescale 1ns / 1ps
`default_nettype none
module qbf_back
	import qbf_pkg::*;
#(
	parameter int MAX_SHIFT = 6,
	parameter int DIRECT_SHIFT = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire qbf_qstat_t                qstat,
	input  wire qbf_item_t                 pop_item,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_W-1:0]      point_x,
	output logic signed [COORD_W-1:0]      point_y,
	output logic                           overflow,
	output logic                           last
);

	localparam int SD = (MAX_SHIFT > DIRECT_SHIFT) ? MAX_SHIFT - DIRECT_SHIFT : 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
	localparam int KW = DIRECT_SHIFT;
	localparam int HW = COORD_W + 2;
	localparam int AW = 64;

	qbf_back_state_t state_q, state_d;
	qbf_curve_t cur_q;
	logic [SHIFT_W-1:0] shift_q;
	qbf_seg_t stack_q [SD];
	logic [SPW-1:0] sp_q;
	logic [KW-1:0] k_q, k_last;
	logic signed [AW-1:0] gx_q, gy_q, d1x_q, d1y_q, d2x_q, d2y_q;
	logic [SHIFT_W:0] nsq;
	logic signed [AW-1:0] rnd, dx, dy, ddx, ddy;
	logic signed [HW-1:0] ax, ay, bx, by, cx, cy;
	qbf_curve_t left_c, right_c;
	qbf_seg_t top_seg;
	logic out_free, step_done;

	assign out_free = !out_valid || !out_stall;
	assign nsq = {shift_q, 1'b0};
	assign rnd = (shift_q != '0) ? (AW'(1) <<< (nsq - 1'b1)) : '0;
	assign k_last = KW'(((KW + 1)'(1) << shift_q) - 1'b1);
	assign step_done = (k_q == k_last);
	assign top_seg = stack_q[SIW'(sp_q - 1'b1)];

	always_comb begin
		ax = HW'(cur_q.ax);
		ay = HW'(cur_q.ay);
		bx = HW'(cur_q.bx);
		by = HW'(cur_q.by);
		cx = HW'(cur_q.cx);
		cy = HW'(cur_q.cy);
		left_c.ax = cur_q.ax;
		left_c.ay = cur_q.ay;
		left_c.bx = COORD_W'((ax + bx + HW'(1)) >>> 1);
		left_c.by = COORD_W'((ay + by + HW'(1)) >>> 1);
		left_c.cx = COORD_W'((ax + bx + bx + cx + HW'(2)) >>> 2);
		left_c.cy = COORD_W'((ay + by + by + cy + HW'(2)) >>> 2);
		right_c.ax = left_c.cx;
		right_c.ay = left_c.cy;
		right_c.bx = COORD_W'((cx + bx + HW'(1)) >>> 1);
		right_c.by = COORD_W'((cy + by + HW'(1)) >>> 1);
		right_c.cx = cur_q.cx;
		right_c.cy = cur_q.cy;
		dx = AW'(cur_q.ax) - AW'(cur_q.bx);
		dy = AW'(cur_q.ay) - AW'(cur_q.by);
		ddx = dx - AW'(cur_q.bx) + AW'(cur_q.cx);
		ddy = dy - AW'(cur_q.by) + AW'(cur_q.cy);
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop = 1'b1;
					if (pop_item.overflow)
						state_d = B_OVF;
					else if (pop_item.seg.shift > SHIFT_W'(DIRECT_SHIFT))
						state_d = B_SPLIT;
					else
						state_d = B_INIT0;
				end
			end
			B_SPLIT: begin
				if (shift_q - 1'b1 > SHIFT_W'(DIRECT_SHIFT))
					state_d = B_SPLIT;
				else
					state_d = B_INIT0;
			end
			B_INIT0: state_d = B_INIT1;
			B_INIT1: state_d = B_STEP;
			B_STEP: begin
				if (out_free && step_done) begin
					if (sp_q == '0)
						state_d = B_IDLE;
					else if (top_seg.shift > SHIFT_W'(DIRECT_SHIFT))
						state_d = B_SPLIT;
					else
						state_d = B_INIT0;
				end
			end
			B_OVF: begin
				if (out_free)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sp_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_SPLIT)
				sp_q <= sp_q + 1'b1;
			else if (state_q == B_STEP && out_free && step_done && sp_q != '0)
				sp_q <= sp_q - 1'b1;
			if ((state_q == B_STEP || state_q == B_OVF) && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				cur_q <= pop_item.seg.curve;
				shift_q <= pop_item.seg.shift;
			end
			B_SPLIT: begin
				stack_q[SIW'(sp_q)] <= '{right_c, shift_q - 1'b1};
				cur_q <= left_c;
				shift_q <= shift_q - 1'b1;
			end
			B_INIT0: begin
				d1x_q <= ddx - (dx <<< (shift_q + 1'b1));
				d1y_q <= ddy - (dy <<< (shift_q + 1'b1));
				d2x_q <= ddx <<< 1;
				d2y_q <= ddy <<< 1;
				gx_q <= AW'(cur_q.ax) <<< nsq;
				gy_q <= AW'(cur_q.ay) <<< nsq;
				k_q <= '0;
			end
			B_INIT1: begin
				gx_q <= gx_q + rnd + d1x_q;
				gy_q <= gy_q + rnd + d1y_q;
				d1x_q <= d1x_q + d2x_q;
				d1y_q <= d1y_q + d2y_q;
			end
			B_STEP: begin
				if (out_free) begin
					point_x <= COORD_W'(((gx_q >>> nsq) + AW'(3)) >>> 6);
					point_y <= COORD_W'(((gy_q >>> nsq) + AW'(3)) >>> 6);
					overflow <= 1'b0;
					last <= step_done && (sp_q == '0);
					gx_q <= gx_q + d1x_q;
					gy_q <= gy_q + d1y_q;
					d1x_q <= d1x_q + d2x_q;
					d1y_q <= d1y_q + d2y_q;
					k_q <= k_q + 1'b1;
					if (step_done && sp_q != '0) begin
						cur_q <= top_seg.curve;
						shift_q <= top_seg.shift;
					end
				end
			end
			B_OVF: begin
				if (out_free) begin
					point_x <= '0;
					point_y <= '0;
					overflow <= 1'b1;
					last <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/quadratic_bezier_flattener_unit.sv
// Top level of the quadratic Bezier flattener.
//
//  channel | direction | handshake            | contents
//  in      | input     | in_valid / in_stall  | spline points, subdivision_shift, restart
//  out     | output    | out_valid / out_stall| point_x, point_y, overflow, last
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front end pushes a fixed-shift request directly and takes an auto request through
// magnitude, error and shift states first. The generator pops a request, splits it at
// midpoints and steps each direct segment by forward differences, one point per cycle
// unless stalled. A two-entry queue lets the front end run ahead while results stall.
// Reset clears the vector count, restores both registers and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_bezier_flattener_unit
	import qbf_pkg::*;
#(
	parameter int MAX_SHIFT = 6,
	parameter int DIRECT_SHIFT = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic signed [COORD_W-1:0] ctrl_x,
	input  wire logic signed [COORD_W-1:0] ctrl_y,
	input  wire logic signed [COORD_W-1:0] end_x,
	input  wire logic signed [COORD_W-1:0] end_y,
	input  wire logic signed [SHIFT_W-1:0] subdivision_shift,
	input  wire logic                      restart,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_W-1:0]      point_x,
	output logic signed [COORD_W-1:0]      point_y,
	output logic                           overflow,
	output logic                           last,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

	qbf_qstat_t qstat;
	qbf_item_t push_item, pop_item;
	logic push, pop;

	qbf_front #(.MAX_SHIFT(MAX_SHIFT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.start_x, .start_y, .ctrl_x, .ctrl_y, .end_x, .end_y,
		.subdivision_shift, .restart,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.qstat, .push, .push_item
	);

	qbf_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .pop_item, .qstat
	);

	qbf_back #(.MAX_SHIFT(MAX_SHIFT), .DIRECT_SHIFT(DIRECT_SHIFT)) u_back (
		.clk, .arst_n, .qstat, .pop_item, .pop,
		.out_valid, .out_stall, .point_x, .point_y, .overflow, .last
	);

	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last && point_x == '0 && point_y == '0)
		else $error("overflow result malformed");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("request pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("request popped from empty queue");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("front end took a second request while busy");

endmodule
`default_nettype wire

FILE: dv/quadratic_bezier_flattener_unit_tb.sv
// Self-checking testbench for the quadratic Bezier flattener unit.
`timescale 1ns / 1ps
`default_nettype none

class qbf_scoreboard;
	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic ovf;
		logic lst;
	} point_t;

	point_t pending_points[$];
	logic [15:0] capacity;
	logic [15:0] threshold;
	logic [63:0] vec_count;
	int errors;
	int results_seen;
	int overflows_seen;

	function new();
		capacity = 16'd257;
		threshold = 16'd128;
		vec_count = 0;
		errors = 0;
		results_seen = 0;
		overflows_seen = 0;
	endfunction

	function logic [63:0] asr(logic [63:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function void emit_segment(logic [63:0] ax, logic [63:0] ay, logic [63:0] bx,
			logic [63:0] by, logic [63:0] cx, logic [63:0] cy, int sh);
		logic [63:0] dx, dy, ddx, ddy, d1x, d1y, d2x, d2y, gx, gy, rnd;
		logic [63:0] mx, my;
		point_t p;
		if (sh > 5) begin
			mx = asr(ax + bx + bx + cx + 2, 2);
			my = asr(ay + by + by + cy + 2, 2);
			emit_segment(ax, ay, asr(ax + bx + 1, 1), asr(ay + by + 1, 1), mx, my, sh - 1);
			emit_segment(mx, my, asr(cx + bx + 1, 1), asr(cy + by + 1, 1), cx, cy, sh - 1);
			return;
		end
		dx = ax - bx;
		dy = ay - by;
		ddx = dx - bx + cx;
		ddy = dy - by + cy;
		d1x = ddx - (dx << (sh + 1));
		d1y = ddy - (dy << (sh + 1));
		d2x = ddx + ddx;
		d2y = ddy + ddy;
		gx = ax << (2 * sh);
		gy = ay << (2 * sh);
		rnd = sh ? (64'd1 << (2 * sh - 1)) : 64'd0;
		for (int k = 0; k < (1 << sh); k++) begin
			gx += d1x;
			gy += d1y;
			p.px = 32'(asr(asr(asr(gx + rnd, 2 * sh) + 3, 3), 3));
			p.py = 32'(asr(asr(asr(gy + rnd, 2 * sh) + 3, 3), 3));
			p.ovf = 0;
			p.lst = 0;
			pending_points.push_back(p);
			d1x += d2x;
			d1y += d2y;
		end
	endfunction

	function void note_request(logic signed [31:0] c[6], logic [3:0] shf, logic rst);
		logic [63:0] v[6];
		logic [63:0] ex, ey, err, sum, t;
		int sh;
		point_t p;
		if (rst)
			vec_count = 0;
		for (int i = 0; i < 6; i++) begin
			v[i] = {{32{c[i][31]}}, c[i]};
			if (shf[3])
				v[i] = asr(v[i], 10);
		end
		if (shf[3]) begin
			t = v[0] - v[2] - v[2] + v[4];
			ex = t[63] ? -t : t;
			t = v[1] - v[3] - v[3] + v[5];
			ey = t[63] ? -t : t;
			err = ex + ((ex > ey) ? ex + ey : ey + ey);
			sh = 1;
			while (err > threshold) begin
				err >>= 2;
				sh++;
			end
			if (sh > 6)
				sh = 6;
			sum = vec_count + (64'd1 << sh);
			vec_count = (sum > 64'hFFFF) ? 64'hFFFF : sum;
			if (sum > capacity) begin
				p.px = 0;
				p.py = 0;
				p.ovf = 1;
				p.lst = 1;
				pending_points.push_back(p);
				return;
			end
		end else begin
			sh = shf[2:0];
			if (sh > 6)
				sh = 6;
		end
		emit_segment(v[0], v[1], v[2], v[3], v[4], v[5], sh);
		pending_points[$].lst = 1;
	endfunction

	function bit check_point(logic signed [31:0] px, logic signed [31:0] py,
			logic ovf, logic lst);
		point_t e;
		results_seen++;
		if (ovf)
			overflows_seen++;
		if (pending_points.size() == 0)
			return 0;
		e = pending_points.pop_front();
		return e.px === px && e.py === py && e.ovf === ovf && e.lst === lst;
	endfunction
endclass

module quadratic_bezier_flattener_unit_tb;
	import qbf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] start_x = 0, start_y = 0, ctrl_x = 0, ctrl_y = 0, end_x = 0, end_y = 0;
	logic [3:0] subdivision_shift = 0;
	logic restart = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] point_x, point_y;
	logic overflow, last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;

	qbf_scoreboard sb = new();
	int cycles = 0;
	int requests_sent = 0;
	int stall_left = 0;
	bit stall_enable = 1;

	quadratic_bezier_flattener_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .ctrl_x(ctrl_x), .ctrl_y(ctrl_y),
		.end_x(end_x), .end_y(end_y), .subdivision_shift(subdivision_shift),
		.restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .overflow(overflow), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("quadratic_bezier_flattener_unit: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("ERROR t=%0t %s: got x=%0d y=%0d ovf=%0b last=%0b", $realtime, what,
			point_x, point_y, overflow, last);
		sb.errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sb.pending_points.size() == 0)
				report_mismatch("unexpected point");
			else if (!sb.check_point(point_x, point_y, overflow, last))
				report_mismatch("point differs");
		end
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 70);
	endfunction

	always @(posedge clk) begin
		if (!stall_enable) begin
			out_stall <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_stall <= 1;
			stall_left <= gap_length();
		end else
			out_stall <= 0;
	end

	task automatic send_request(logic signed [31:0] c[6], logic [3:0] shf, logic rst);
		int g;
		g = gap_length();
		repeat (g) @(posedge clk);
		start_x <= c[0];
		start_y <= c[1];
		ctrl_x <= c[2];
		ctrl_y <= c[3];
		end_x <= c[4];
		end_y <= c[5];
		subdivision_shift <= shf;
		restart <= rst;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(c, shf, rst);
		requests_sent++;
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_VECTOR_CAPACITY)
			sb.capacity = val;
		else if (idx == CFG_FLATNESS_THRESHOLD)
			sb.threshold = val;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom_range(0, 4000) - 2000;
			1: return ($urandom_range(0, 65535) - 32768) <<< 10;
			2: return $urandom();
			default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		endcase
	endfunction

	task automatic random_request();
		logic signed [31:0] c[6];
		logic [3:0] shf;
		int mode, r;
		r = $urandom_range(0, 99);
		mode = (r < 40) ? 0 : (r < 75) ? 1 : (r < 92) ? 2 : 3;
		for (int i = 0; i < 6; i++)
			c[i] = rand_coord(mode);
		r = $urandom_range(0, 99);
		if (r < 45)
			shf = 4'hF;
		else if (r < 50)
			shf = 4'h8 | 4'($urandom_range(0, 6));
		else if (r < 85)
			shf = 4'($urandom_range(0, 4));
		else
			shf = 4'($urandom_range(5, 7));
		send_request(c, shf, $urandom_range(0, 9) == 0);
	endtask

	initial begin
		logic signed [31:0] c[6];
		logic [15:0] caps[4] = '{16'd257, 16'd1, 16'd65535, 16'd40};
		logic [15:0] thrs[4] = '{16'd128, 16'd65535, 16'd1, 16'd500};

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		c = '{0, 0, 0, 0, 0, 0};
		for (int s = 0; s < 8; s++)
			send_request(c, 4'(s), 0);
		c = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh80000000, 32'sh7FFFFFFF};
		send_request(c, 4'd6, 0);
		send_request(c, 4'd0, 0);
		send_request(c, 4'hF, 1);
		c = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh80000000};
		send_request(c, 4'hF, 0);
		send_request(c, 4'd3, 0);
		c = '{0, 0, 32'sh00100000, 32'sh00200000, 32'sh00400000, 0};
		for (int i = 0; i < 6; i++)
			send_request(c, 4'hF, i == 0);
		c = '{0, 0, 64, 0, 128, 0};
		send_request(c, 4'hF, 0);
		send_request(c, 4'hA, 1);
		drain();
		write_register(8'd7, 16'h1234);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_register(CFG_VECTOR_CAPACITY, caps[ph]);
			write_register(CFG_FLATNESS_THRESHOLD, thrs[ph]);
			stall_enable = (ph != 2);
			for (int i = 0; i < 63; i++)
				random_request();
		end
		stall_enable = 1;
		drain();
		$display("Sent %0d splines, checked %0d points (%0d overflow results).",
			requests_sent, sb.results_seen, sb.overflows_seen);
		$display("Covered fixed and auto shifts, midpoint splits, and four register settings.");
		if (sb.errors == 0 && sb.pending_points.size() == 0)
			$display("quadratic_bezier_flattener_unit: match");
		else
			$display("quadratic_bezier_flattener_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
